// ----- rtl/core/cga_pkg.sv -----
// Shared constants, types and helper functions for the CGA register port.
package cga_pkg;

	// Default sizes of the CRTC bank and the text screen.
	localparam int CRTC_COUNT_DEF   = 18;
	localparam int TEXT_COLUMNS_DEF = 80;
	localparam int TEXT_CELLS_DEF   = 2000;

	// Port offsets inside the 16-byte window.
	localparam logic [3:0] PORT_CRTC_INDEX = 4'h0;
	localparam logic [3:0] PORT_CRTC_DATA  = 4'h1;
	localparam logic [3:0] PORT_MODE       = 4'h4;
	localparam logic [3:0] PORT_PALETTE    = 4'h5;
	localparam logic [3:0] PORT_STATUS     = 4'h6;

	// CRTC register indexes that drive the cursor and the display start.
	localparam logic [7:0] REG_CUR_START = 8'h0a;
	localparam logic [7:0] REG_CUR_END   = 8'h0b;
	localparam logic [7:0] REG_START_HI  = 8'h0c;
	localparam logic [7:0] REG_START_LO  = 8'h0d;
	localparam logic [7:0] REG_CUR_HI    = 8'h0e;
	localparam logic [7:0] REG_CUR_LO    = 8'h0f;

	// Highest CRTC index that reads back.
	localparam logic [7:0] CRTC_READ_MAX = 8'h0f;
	localparam logic [7:0] UNMAPPED_BYTE = 8'hff;
	localparam logic [7:0] LAST_CUR_LINE = 8'h07;

	// Fixed palette entries 1 to 3 for colour set zero; set one clears bit 0.
	localparam logic [3:0] PAL1_SET0 = 4'd11;
	localparam logic [3:0] PAL2_SET0 = 4'd13;
	localparam logic [3:0] PAL3_SET0 = 4'd15;

	// Last value of the status read counter before it wraps to zero.
	localparam logic [5:0] STATUS_LAST = 6'd63;

	typedef enum logic [1:0] {
		MODE_TEXT = 2'd0,
		MODE_GFX4 = 2'd1,
		MODE_GFX2 = 2'd2
	} video_mode_t;

	// Scale a character line of 0 to 7 onto the 0 to 255 range.
	function automatic logic [7:0] scale_line(input logic [2:0] y);
		logic [7:0] ye;
		ye = {5'd0, y};
		return (ye << 5) | (ye << 2) | (ye >> 1);
	endfunction

	// Decode a mode register byte.
	function automatic video_mode_t decode_mode(input logic [7:0] v);
		video_mode_t m;
		if (!v[1]) begin
			m = MODE_TEXT;
		end else if (!v[4]) begin
			m = MODE_GFX4;
		end else begin
			m = MODE_GFX2;
		end
		return m;
	endfunction

endpackage

// ----- rtl/core/cga_register_port.sv -----
// An input item waits in the input register until the result register is free.
// Throughput: one item per cycle unless the result stalls; the two registers part
// the two channels, and all state updates in the single pass between them.
// Reset: arst_n at once clears the CRTC bank, the port bytes, the status counter and
// the cursor extents and cell, shows the cursor and sets the palette to 0, 11, 13, 15.
// The display fields show the state after the access whose result item is on offer.
// Top level of the CGA register port: CRTC bank, mode, palette and cursor logic.
module cga_register_port #(
	parameter int CRTC_COUNT   = cga_pkg::CRTC_COUNT_DEF,
	parameter int TEXT_COLUMNS = cga_pkg::TEXT_COLUMNS_DEF,
	parameter int TEXT_CELLS   = cga_pkg::TEXT_CELLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [3:0]  addr,
	input  logic [7:0]  wdata,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  rdata,
	output logic [1:0]  video_mode,
	output logic [3:0]  bg_color,
	output logic [3:0]  pal_color1,
	output logic [3:0]  pal_color2,
	output logic [3:0]  pal_color3,
	output logic        cursor_enabled,
	output logic [7:0]  cursor_top,
	output logic [7:0]  cursor_bottom,
	output logic [6:0]  cursor_col,
	output logic [4:0]  cursor_row,
	output logic [15:0] page_offset
);

	localparam int IDX_W  = $clog2(CRTC_COUNT);
	localparam int REL_W  = $clog2(TEXT_CELLS);
	localparam int DIV_W  = REL_W + 1;
	localparam int QUOT_W = $clog2(TEXT_CELLS / TEXT_COLUMNS + 1);

	// Input register.
	logic       valid_s1;
	logic       op_s1;
	logic [3:0] addr_s1;
	logic [7:0] wdata_s1;

	// Result register.
	logic       out_valid_q;
	logic [7:0] rdata_q;

	// Architectural state.
	logic [7:0]           crtc_q [CRTC_COUNT];
	logic [7:0]           index_q;
	logic [7:0]           status_q;
	logic [5:0]           reads_q;
	cga_pkg::video_mode_t mode_q;
	logic                 pal_sel_q;
	logic [3:0]           bg_q;
	logic                 cur_on_q;
	logic [7:0]           cur_top_q;
	logic [7:0]           cur_bot_q;
	logic [6:0]           cur_col_q;
	logic [4:0]           cur_row_q;
	logic [15:0]          start_q;

	logic advance;
	logic wr;
	logic crtc_wr;
	logic idx_in_bank;
	logic [IDX_W-1:0] idx;

	logic [7:0]  y1;
	logic [7:0]  y2;
	logic [15:0] pos;
	logic [16:0] diff;
	logic        pos_ok;
	logic [DIV_W-1:0]  rem;
	logic [QUOT_W-1:0] quot;
	logic [5:0]  reads_next;
	logic [7:0]  status_next;
	logic [7:0]  rdata_next;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign idx         = index_q[IDX_W-1:0];
	assign idx_in_bank = index_q < 8'(CRTC_COUNT);
	assign wr          = advance && op_s1;
	assign crtc_wr     = wr && (addr_s1 == cga_pkg::PORT_CRTC_DATA) && idx_in_bank;

	// Cursor shape uses the byte being written in place of its stored copy.
	always_comb begin
		y1 = (index_q == cga_pkg::REG_CUR_START) ? wdata_s1
			: crtc_q[IDX_W'(cga_pkg::REG_CUR_START)];
		y2 = (index_q == cga_pkg::REG_CUR_END) ? wdata_s1
			: crtc_q[IDX_W'(cga_pkg::REG_CUR_END)];
		if (y2 < y1 || y2 > cga_pkg::LAST_CUR_LINE) begin
			y2 = cga_pkg::LAST_CUR_LINE;
		end
	end

	// Cursor address relative to the display start, split by restoring
	// division against shifted copies of the column count.
	always_comb begin
		pos    = {crtc_q[IDX_W'(cga_pkg::REG_CUR_HI)], wdata_s1};
		diff   = {1'b0, pos} - {1'b0, start_q};
		pos_ok = !diff[16] && (diff[15:0] < 16'(TEXT_CELLS));
		rem    = DIV_W'(diff[REL_W-1:0]);
		quot   = '0;
		for (int k = QUOT_W - 1; k >= 0; k--) begin
			if (rem >= DIV_W'(TEXT_COLUMNS * (1 << k))) begin
				rem     = rem - DIV_W'(TEXT_COLUMNS * (1 << k));
				quot[k] = 1'b1;
			end
		end
	end

	// Status byte: bit 0 flips every eighth read, bit 3 when the count wraps.
	always_comb begin
		reads_next  = reads_q + 6'd1;
		status_next = status_q;
		if (reads_next[2:0] == 3'd0) begin
			status_next[0] = ~status_next[0];
		end
		if (reads_q == cga_pkg::STATUS_LAST) begin
			status_next[3] = ~status_next[3];
		end
	end

	always_comb begin
		rdata_next = cga_pkg::UNMAPPED_BYTE;
		if (!op_s1) begin
			case (addr_s1)
				cga_pkg::PORT_CRTC_INDEX: begin
					rdata_next = index_q;
				end
				cga_pkg::PORT_CRTC_DATA: begin
					if (index_q <= cga_pkg::CRTC_READ_MAX && idx_in_bank) begin
						rdata_next = crtc_q[idx];
					end
				end
				cga_pkg::PORT_STATUS: begin
					rdata_next = status_next;
				end
				default: begin
					rdata_next = cga_pkg::UNMAPPED_BYTE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= op;
			addr_s1  <= addr;
			wdata_s1 <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rdata_q <= rdata_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CRTC_COUNT; i++) begin
				crtc_q[i] <= '0;
			end
		end else if (crtc_wr) begin
			crtc_q[idx] <= wdata_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q   <= '0;
			status_q  <= '0;
			reads_q   <= '0;
			mode_q    <= cga_pkg::MODE_TEXT;
			pal_sel_q <= 1'b0;
			bg_q      <= '0;
			cur_on_q  <= 1'b1;
			cur_top_q <= '0;
			cur_bot_q <= '0;
			cur_col_q <= '0;
			cur_row_q <= '0;
			start_q   <= '0;
		end else if (advance) begin
			if (op_s1) begin
				case (addr_s1)
					cga_pkg::PORT_CRTC_INDEX: begin
						index_q <= wdata_s1;
					end
					cga_pkg::PORT_MODE: begin
						mode_q <= cga_pkg::decode_mode(wdata_s1);
					end
					cga_pkg::PORT_PALETTE: begin
						pal_sel_q <= ~wdata_s1[5];
						bg_q      <= wdata_s1[3:0];
					end
					cga_pkg::PORT_STATUS: begin
						status_q <= wdata_s1;
					end
					default: begin
					end
				endcase
			end else if (addr_s1 == cga_pkg::PORT_STATUS) begin
				status_q <= status_next;
				reads_q  <= (reads_q == cga_pkg::STATUS_LAST) ? 6'd0 : reads_next;
			end

			if (crtc_wr) begin
				if (index_q == cga_pkg::REG_CUR_START || index_q == cga_pkg::REG_CUR_END) begin
					if (mode_q == cga_pkg::MODE_TEXT) begin
						if (y1 > cga_pkg::LAST_CUR_LINE) begin
							cur_on_q  <= 1'b0;
							cur_top_q <= '0;
							cur_bot_q <= '0;
						end else begin
							cur_on_q  <= 1'b1;
							cur_top_q <= cga_pkg::scale_line(y1[2:0]);
							cur_bot_q <= cga_pkg::scale_line(y2[2:0]);
						end
					end
				end else if (index_q == cga_pkg::REG_START_HI) begin
					start_q[15:8] <= wdata_s1;
				end else if (index_q == cga_pkg::REG_START_LO) begin
					start_q[7:0] <= wdata_s1;
				end else if (index_q == cga_pkg::REG_CUR_LO) begin
					if (mode_q == cga_pkg::MODE_TEXT && pos_ok) begin
						cur_col_q <= 7'(rem);
						cur_row_q <= 5'(quot);
					end
				end
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign rdata          = rdata_q;
	assign video_mode     = mode_q;
	assign bg_color       = bg_q;
	assign pal_color1     = {cga_pkg::PAL1_SET0[3:1], cga_pkg::PAL1_SET0[0] & ~pal_sel_q};
	assign pal_color2     = {cga_pkg::PAL2_SET0[3:1], cga_pkg::PAL2_SET0[0] & ~pal_sel_q};
	assign pal_color3     = {cga_pkg::PAL3_SET0[3:1], cga_pkg::PAL3_SET0[0] & ~pal_sel_q};
	assign cursor_enabled = cur_on_q;
	assign cursor_top     = cur_top_q;
	assign cursor_bottom  = cur_bot_q;
	assign cursor_col     = cur_col_q;
	assign cursor_row     = cur_row_q;
	assign page_offset    = start_q;

endmodule

// ----- rtl/core/cga_port_chk.sv -----
// Port-level checker for the CGA register port, bound to the top level.
module cga_port_chk #(
	parameter int TEXT_COLUMNS = cga_pkg::TEXT_COLUMNS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  rdata,
	input logic [1:0]  video_mode,
	input logic [3:0]  pal_color1,
	input logic [3:0]  pal_color2,
	input logic [3:0]  pal_color3,
	input logic        cursor_enabled,
	input logic [7:0]  cursor_top,
	input logic [7:0]  cursor_bottom,
	input logic [6:0]  cursor_col
);

	// A stalled result item keeps its place and its byte.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rdata))
		else $error("result item changed while stalled");

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		video_mode != 2'd3)
		else $error("video mode code three shown");

	// A hidden cursor has both extents cleared.
	a_cursor_off: assert property (@(posedge clk) disable iff (!arst_n)
		!cursor_enabled |-> cursor_top == 8'd0 && cursor_bottom == 8'd0)
		else $error("hidden cursor with nonzero extents");

	// Entries 1 to 3 always come from one of the two fixed colour sets.
	a_palette_set: assert property (@(posedge clk) disable iff (!arst_n)
		pal_color1[3:1] == 3'b101 && pal_color2[3:1] == 3'b110 &&
		pal_color3[3:1] == 3'b111 && pal_color1[0] == pal_color2[0] &&
		pal_color2[0] == pal_color3[0])
		else $error("palette entries outside the fixed colour sets");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cursor_col) < TEXT_COLUMNS)
		else $error("cursor column beyond the screen width");

endmodule

bind cga_register_port cga_port_chk #(.TEXT_COLUMNS(TEXT_COLUMNS)) u_cga_port_chk (.*);

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the CGA register port, with directed and random bus accesses.
module tb;

	localparam logic OP_READ      = 1'b0;
	localparam logic OP_WRITE     = 1'b1;
	localparam logic [7:0] STATUS_BLINK = 8'h01;
	localparam logic [7:0] STATUS_FRAME = 8'h08;
	localparam int   STALL_LIMIT  = 500;
	localparam int   DRAIN_CYCLES = 8;
	localparam int   RANDOM_ITEMS = 1200;

	typedef struct {
		logic [7:0]  rdata;
		logic [1:0]  video_mode;
		logic [3:0]  bg_color;
		logic [3:0]  pal_color1;
		logic [3:0]  pal_color2;
		logic [3:0]  pal_color3;
		logic        cursor_enabled;
		logic [7:0]  cursor_top;
		logic [7:0]  cursor_bottom;
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [15:0] page_offset;
	} port_view_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic        op        = 1'b0;
	logic [3:0]  addr      = 4'h0;
	logic [7:0]  wdata     = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  rdata;
	logic [1:0]  video_mode;
	logic [3:0]  bg_color;
	logic [3:0]  pal_color1;
	logic [3:0]  pal_color2;
	logic [3:0]  pal_color3;
	logic        cursor_enabled;
	logic [7:0]  cursor_top;
	logic [7:0]  cursor_bottom;
	logic [6:0]  cursor_col;
	logic [4:0]  cursor_row;
	logic [15:0] page_offset;

	// Shadow copy of the adapter state, as it stands after the latest accepted item.
	logic [7:0]  shadow_ports [16] = '{default: 8'h00};
	logic [7:0]  shadow_crtc [cga_pkg::CRTC_COUNT_DEF] = '{default: 8'h00};
	cga_pkg::video_mode_t shadow_mode = cga_pkg::MODE_TEXT;
	logic [3:0]  shadow_pal [4] = '{4'd0, cga_pkg::PAL1_SET0, cga_pkg::PAL2_SET0,
		cga_pkg::PAL3_SET0};
	logic        shadow_cur_on = 1'b1;
	logic [7:0]  shadow_cur_top = 8'h00;
	logic [7:0]  shadow_cur_bot = 8'h00;
	logic [6:0]  shadow_col = 7'd0;
	logic [4:0]  shadow_row = 5'd0;
	logic [15:0] shadow_start = 16'h0000;
	logic [6:0]  status_count = 7'd0;

	port_view_t pending_views [$];
	int fail_count   = 0;
	int quiet_cycles = 0;
	int hold_off     = 0;
	int rx_stall     = 0;
	bit tx_idling    = 1'b1;
	bit rx_idling    = 1'b1;

	cga_register_port dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.addr           (addr),
		.wdata          (wdata),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.rdata          (rdata),
		.video_mode     (video_mode),
		.bg_color       (bg_color),
		.pal_color1     (pal_color1),
		.pal_color2     (pal_color2),
		.pal_color3     (pal_color3),
		.cursor_enabled (cursor_enabled),
		.cursor_top     (cursor_top),
		.cursor_bottom  (cursor_bottom),
		.cursor_col     (cursor_col),
		.cursor_row     (cursor_row),
		.page_offset    (page_offset)
	);

	always #5 clk = ~clk;

	// A character line of 0 to 7 spread over 0 to 255: 36 per line plus half the line.
	function automatic logic [7:0] cursor_scan(input logic [7:0] y);
		return 8'(int'(y) * 36 + int'(y) / 2);
	endfunction

	// Applies one bus access to the shadow state and returns the view that it leaves.
	function automatic port_view_t apply_access(input logic wr, input logic [3:0] port,
			input logic [7:0] data);
		port_view_t v;
		logic [7:0] idx;
		logic [7:0] y1;
		logic [7:0] y2;
		int pos;
		int rel;
		v.rdata = cga_pkg::UNMAPPED_BYTE;
		idx = shadow_ports[cga_pkg::PORT_CRTC_INDEX];
		if (wr) begin
			shadow_ports[port] = data;
			case (port)
			cga_pkg::PORT_CRTC_DATA: begin
				if (idx < cga_pkg::CRTC_COUNT_DEF) begin
					shadow_crtc[idx] = data;
					if ((idx == cga_pkg::REG_CUR_START || idx == cga_pkg::REG_CUR_END) &&
							shadow_mode == cga_pkg::MODE_TEXT) begin
						y1 = shadow_crtc[cga_pkg::REG_CUR_START];
						y2 = shadow_crtc[cga_pkg::REG_CUR_END];
						if (y1 > cga_pkg::LAST_CUR_LINE) begin
							shadow_cur_on = 1'b0;
							shadow_cur_top = 8'h00;
							shadow_cur_bot = 8'h00;
						end else begin
							if (y2 < y1 || y2 > cga_pkg::LAST_CUR_LINE)
								y2 = cga_pkg::LAST_CUR_LINE;
							shadow_cur_on = 1'b1;
							shadow_cur_top = cursor_scan(y1);
							shadow_cur_bot = cursor_scan(y2);
						end
					end else if (idx == cga_pkg::REG_START_HI ||
							idx == cga_pkg::REG_START_LO) begin
						shadow_start = {shadow_crtc[cga_pkg::REG_START_HI],
							shadow_crtc[cga_pkg::REG_START_LO]};
					end else if (idx == cga_pkg::REG_CUR_LO &&
							shadow_mode == cga_pkg::MODE_TEXT) begin
						pos = int'({shadow_crtc[cga_pkg::REG_CUR_HI],
							shadow_crtc[cga_pkg::REG_CUR_LO]});
						rel = pos - int'(shadow_start);
						// A cursor outside the visible page leaves the old cell in place.
						if (rel >= 0 && rel < cga_pkg::TEXT_CELLS_DEF) begin
							shadow_col = 7'(rel % cga_pkg::TEXT_COLUMNS_DEF);
							shadow_row = 5'(rel / cga_pkg::TEXT_COLUMNS_DEF);
						end
					end
				end
			end
			cga_pkg::PORT_MODE: begin
				if (!data[1])
					shadow_mode = cga_pkg::MODE_TEXT;
				else if (!data[4])
					shadow_mode = cga_pkg::MODE_GFX4;
				else
					shadow_mode = cga_pkg::MODE_GFX2;
			end
			cga_pkg::PORT_PALETTE: begin
				shadow_pal[0] = data[3:0];
				if (data[5]) begin
					shadow_pal[1] = cga_pkg::PAL1_SET0;
					shadow_pal[2] = cga_pkg::PAL2_SET0;
					shadow_pal[3] = cga_pkg::PAL3_SET0;
				end else begin
					shadow_pal[1] = cga_pkg::PAL1_SET0 & 4'he;
					shadow_pal[2] = cga_pkg::PAL2_SET0 & 4'he;
					shadow_pal[3] = cga_pkg::PAL3_SET0 & 4'he;
				end
			end
			default: ;
			endcase
		end else begin
			case (port)
			cga_pkg::PORT_CRTC_INDEX: v.rdata = idx;
			cga_pkg::PORT_CRTC_DATA: begin
				if (idx <= cga_pkg::CRTC_READ_MAX)
					v.rdata = shadow_crtc[idx];
			end
			cga_pkg::PORT_STATUS: begin
				status_count = status_count + 7'd1;
				if (status_count[2:0] == 3'd0)
					shadow_ports[cga_pkg::PORT_STATUS] =
						shadow_ports[cga_pkg::PORT_STATUS] ^ STATUS_BLINK;
				if (status_count > 7'(cga_pkg::STATUS_LAST)) begin
					status_count = 7'd0;
					shadow_ports[cga_pkg::PORT_STATUS] =
						shadow_ports[cga_pkg::PORT_STATUS] ^ STATUS_FRAME;
				end
				v.rdata = shadow_ports[cga_pkg::PORT_STATUS];
			end
			default: ;
			endcase
		end
		v.video_mode     = shadow_mode;
		v.bg_color       = shadow_pal[0];
		v.pal_color1     = shadow_pal[1];
		v.pal_color2     = shadow_pal[2];
		v.pal_color3     = shadow_pal[3];
		v.cursor_enabled = shadow_cur_on;
		v.cursor_top     = shadow_cur_top;
		v.cursor_bottom  = shadow_cur_bot;
		v.cursor_col     = shadow_col;
		v.cursor_row     = shadow_row;
		v.page_offset    = shadow_start;
		return v;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Mostly no gap, often a short one and now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin : scoreboard
		port_view_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_views.size() == 0) begin
					$error("result item arrived with nothing outstanding");
					fail_count++;
				end else begin
					want = pending_views.pop_front();
					check_field("rdata", 16'(want.rdata), 16'(rdata));
					check_field("video_mode", 16'(want.video_mode), 16'(video_mode));
					check_field("bg_color", 16'(want.bg_color), 16'(bg_color));
					check_field("pal_color1", 16'(want.pal_color1), 16'(pal_color1));
					check_field("pal_color2", 16'(want.pal_color2), 16'(pal_color2));
					check_field("pal_color3", 16'(want.pal_color3), 16'(pal_color3));
					check_field("cursor_enabled", 16'(want.cursor_enabled),
						16'(cursor_enabled));
					check_field("cursor_top", 16'(want.cursor_top), 16'(cursor_top));
					check_field("cursor_bottom", 16'(want.cursor_bottom),
						16'(cursor_bottom));
					check_field("cursor_col", 16'(want.cursor_col), 16'(cursor_col));
					check_field("cursor_row", 16'(want.cursor_row), 16'(cursor_row));
					check_field("page_offset", want.page_offset, page_offset);
				end
			end
			if (in_valid && in_ready)
				pending_views.push_back(apply_access(op, addr, wdata));
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** cga_register_port: FAILED **");
			$finish;
		end
	end

	// Receiver: a long hold-off when asked for, random stalls otherwise while rx_idling is set.
	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off--;
		end else if (rx_stall > 0) begin
			out_ready <= 1'b0;
			rx_stall--;
		end else begin
			out_ready <= 1'b1;
			if (rx_idling)
				rx_stall = pick_gap();
		end
	end

	task automatic send_access(input logic wr, input logic [3:0] port, input logic [7:0] data);
		int gap;
		gap = tx_idling ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= wr;
		addr <= port;
		wdata <= data;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic set_crtc(input logic [7:0] idx, input logic [7:0] data);
		send_access(OP_WRITE, cga_pkg::PORT_CRTC_INDEX, idx);
		send_access(OP_WRITE, cga_pkg::PORT_CRTC_DATA, data);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_port_reads();
		send_access(OP_READ, cga_pkg::PORT_CRTC_INDEX, 8'h00);
		send_access(OP_READ, cga_pkg::PORT_CRTC_DATA, 8'hff);
		send_access(OP_READ, cga_pkg::PORT_STATUS, 8'h00);
	endtask

	// The cursor write in graphics mode must leave the cursor alone.
	task automatic test_mode_palette();
		send_access(OP_WRITE, cga_pkg::PORT_MODE, 8'h12);
		set_crtc(cga_pkg::REG_CUR_START, 8'h03);
		send_access(OP_WRITE, cga_pkg::PORT_MODE, 8'h00);
		send_access(OP_WRITE, cga_pkg::PORT_PALETTE, 8'hff);
		send_access(OP_WRITE, cga_pkg::PORT_PALETTE, 8'h10);
	endtask

	task automatic test_cursor_shape();
		set_crtc(cga_pkg::REG_CUR_START, 8'h06);
		set_crtc(cga_pkg::REG_CUR_END, 8'h03);
		send_access(OP_WRITE, cga_pkg::PORT_CRTC_DATA, 8'hff);
		set_crtc(cga_pkg::REG_CUR_START, 8'h08);
	endtask

	// Page starts at cell 16; the cursor lands on the last cell, then one past it.
	task automatic test_cursor_position();
		set_crtc(cga_pkg::REG_START_LO, 8'h10);
		set_crtc(cga_pkg::REG_CUR_HI, 8'h07);
		set_crtc(cga_pkg::REG_CUR_LO, 8'hdf);
		send_access(OP_WRITE, cga_pkg::PORT_CRTC_DATA, 8'he0);
	endtask

	task automatic test_bank_limits();
		set_crtc(8'(cga_pkg::CRTC_COUNT_DEF - 1), 8'ha5);
		send_access(OP_READ, cga_pkg::PORT_CRTC_DATA, 8'h00);
		set_crtc(8'hff, 8'h5a);
		send_access(OP_READ, cga_pkg::PORT_CRTC_INDEX, 8'h00);
	endtask

	task automatic send_random_sequence(output int sent);
		int kind;
		int burst;
		logic [7:0] idx;
		logic [7:0] data;
		kind = $urandom_range(0, 99);
		sent = 1;
		if (kind < 40) begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: idx = 8'($urandom_range(cga_pkg::REG_CUR_START,
				cga_pkg::REG_CUR_LO));
			6, 7: idx = 8'($urandom_range(0, cga_pkg::CRTC_COUNT_DEF - 1));
			default: idx = 8'($urandom);
			endcase
			data = 8'($urandom);
			if ($urandom_range(0, 3) != 0) begin
				// Small values keep the cursor lines and positions near the visible page.
				if (idx == cga_pkg::REG_CUR_START || idx == cga_pkg::REG_CUR_END)
					data = 8'($urandom_range(0, 9));
				else if (idx == cga_pkg::REG_START_HI || idx == cga_pkg::REG_CUR_HI)
					data = 8'($urandom_range(0, 8));
			end
			send_access(OP_WRITE, cga_pkg::PORT_CRTC_INDEX, idx);
			if ($urandom_range(0, 3) != 0)
				send_access(OP_WRITE, cga_pkg::PORT_CRTC_DATA, data);
			else
				send_access(OP_READ, cga_pkg::PORT_CRTC_DATA, 8'($urandom));
			sent = 2;
		end else if (kind < 50) begin
			data = 8'($urandom);
			if ($urandom_range(0, 9) < 6)
				data[1] = 1'b0;
			send_access(OP_WRITE, cga_pkg::PORT_MODE, data);
		end else if (kind < 58) begin
			send_access(OP_WRITE, cga_pkg::PORT_PALETTE, 8'($urandom));
		end else if (kind < 72) begin
			burst = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : 1;
			repeat (burst) send_access(OP_READ, cga_pkg::PORT_STATUS, 8'($urandom));
			sent = burst;
		end else if (kind < 78) begin
			send_access(OP_WRITE, cga_pkg::PORT_STATUS, 8'($urandom));
		end else begin
			send_access(1'($urandom), 4'($urandom), 8'($urandom));
		end
	endtask

	// The receiver holds off while the sender keeps offering, so the block must stall.
	task automatic test_backpressure();
		int sent;
		tx_idling = 1'b0;
		hold_off = 80;
		repeat (12) send_random_sequence(sent);
		wait_for_results();
		tx_idling = 1'b1;
	endtask

	task automatic test_random();
		int total;
		int chunk;
		int sent;
		total = 0;
		while (total < RANDOM_ITEMS) begin
			// Each stretch draws its own idling; some run flat out on one or both sides.
			tx_idling = ($urandom_range(0, 3) != 0);
			rx_idling = ($urandom_range(0, 3) != 0);
			chunk = 0;
			while (chunk < 100) begin
				send_random_sequence(sent);
				chunk += sent;
			end
			total += chunk;
			if ($urandom_range(0, 3) == 0)
				wait_for_results();
		end
		tx_idling = 1'b1;
		rx_idling = 1'b1;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_port_reads();
		test_mode_palette();
		test_cursor_shape();
		test_cursor_position();
		test_bank_limits();
		test_backpressure();
		test_random();
		wait_for_results();
		if (fail_count == 0)
			$display("** cga_register_port: PASSED **");
		else
			$display("** cga_register_port: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/cga_pkg.sv
rtl/core/cga_register_port.sv
rtl/core/cga_port_chk.sv
test/tb.sv
